>>> design/pmbr_pkg.sv
// Package: shared types, codes and colour constants for the peak meter bar renderer.
`default_nettype none

package pmbr_pkg;

  localparam int LEVEL_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int TIMER_W    = 8;
  localparam int FADE_W     = 8;

  localparam logic [LEVEL_W-1:0] FULL_SCALE = 16'd32768;

  // request codes
  localparam logic [1:0] REQ_SAMPLE      = 2'd0;
  localparam logic [1:0] REQ_PULSE       = 2'd1;
  localparam logic [1:0] REQ_RESET_PEAKS = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCKED = 3'd4;

  // register reset values
  localparam logic [2:0]         ACTIVE_RST = 3'd2;
  localparam logic [15:0]        DECAY_RST  = 16'd62915;
  localparam logic [FADE_W-1:0]  FADE_RST   = 8'd100;
  localparam logic [TIMER_W-1:0] HOLD_RST   = 8'd100;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } pixel_t;

  localparam pixel_t COL_FILL  = '{r: 8'd41,  g: 8'd120, b: 8'd45};
  localparam pixel_t COL_CUR   = '{r: 8'd45,  g: 8'd255, b: 8'd45};
  localparam pixel_t COL_EMPTY = '{r: 8'd15,  g: 8'd36,  b: 8'd16};
  localparam pixel_t COL_PEAK  = '{r: 8'd255, g: 8'd229, b: 8'd87};
  localparam pixel_t COL_OVER  = '{r: 8'd255, g: 8'd89,  b: 8'd7};

  // where the segment being drawn sits relative to the markers
  typedef struct packed {
    logic below;
    logic at_cur;
    logic at_peak;
    logic top_over;
  } seg_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECAY,
    ST_HOLD,
    ST_LOCATE,
    ST_READ,
    ST_WRITE,
    ST_CLOSE
  } pmbr_state_t;

endpackage

`default_nettype wire

>>> design/pmbr_if.sv
// Interfaces: request, result and configuration channels.
`default_nettype none

interface pmbr_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [1:0]  channel;
  logic [15:0] level;

  modport source (output valid, req_type, channel, level, input ready);
  modport sink (input valid, req_type, channel, level, output ready);
endinterface

interface pmbr_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] out_channel;
  logic [3:0] segment;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       last_of_run;

  modport source (output valid, out_channel, segment, red, green, blue, last_of_run,
                  input ready);
  modport sink (input valid, out_channel, segment, red, green, blue, last_of_run,
                output ready);
endinterface

interface pmbr_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> design/pmbr_pixel_mem.sv
// Pixel store: single-port-write RAM with registered read and per-entry valid bits.
`default_nettype none

module pmbr_pixel_mem
  import pmbr_pkg::*;
#(
  parameter int DEPTH  = 32,
  parameter int ADDR_W = 5
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              flush,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output pixel_t                 rd_data,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire pixel_t            wr_data
);

  pixel_t           mem [DEPTH];
  logic [DEPTH-1:0] written;
  pixel_t           raw;
  logic             raw_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      raw <= mem[rd_addr];
    end
  end

  // unwritten entries read as black
  always_ff @(posedge clk) begin
    if (rst || flush) begin
      written   <= '0;
      raw_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        raw_valid <= written[rd_addr];
      end
    end
  end

  assign rd_data = raw_valid ? raw : pixel_t'('0);

endmodule

`default_nettype wire

>>> design/pmbr_shade.sv
// Segment shader: fades the old colour and applies fill, markers and overshoot.
`default_nettype none

module pmbr_shade
  import pmbr_pkg::*;
(
  input  wire pixel_t              old_px,
  input  wire logic [FADE_W-1:0]   fade_gain,
  input  wire seg_ctl_t            ctl,
  output pixel_t                   new_px
);

  function automatic logic [7:0] fade_max(input logic [7:0] old_c,
                                          input logic [FADE_W-1:0] gain,
                                          input logic [7:0] base);
    logic [15:0] prod;
    logic [7:0]  f;
    prod = 16'(old_c) * 16'(gain);
    f    = prod[15:8];
    return (f > base) ? f : base;
  endfunction

  pixel_t base;

  always_comb begin
    base = ctl.below ? COL_FILL : COL_EMPTY;
    if (ctl.at_cur) begin
      new_px = COL_CUR;
    end else begin
      new_px.r = fade_max(old_px.r, fade_gain, base.r);
      new_px.g = fade_max(old_px.g, fade_gain, base.g);
      new_px.b = fade_max(old_px.b, fade_gain, base.b);
    end
    if (ctl.at_peak) begin
      new_px = COL_PEAK;
    end
    if (ctl.top_over) begin
      new_px = COL_OVER;
    end
  end

endmodule

`default_nettype wire

>>> design/peak_meter_bar_render_top.sv
// Top level: peak meter with decaying hold, rendering bar columns into a pixel store.
`default_nettype none

// Multi-channel peak meter. Sample requests (type 0) raise the channel's running
// maximum and, above full scale (32768), arm its overshoot timer; they may come
// back to back, as may reset-peaks requests (type 2). A pulse request (type 1)
// walks the active channels from the highest down: it decays the held peak (one
// 16x16 multiply, registered), then re-renders the channel's column by
// read-modify-write of the pixel RAM, one segment per read and one per write,
// sending each new segment as a result. A pulse holds the request side off until
// every active channel has gone through its decay, hold, locate, read/write and
// close states, and while the result side stalls; the single RAM port pair sets
// this. Results pass through an output register, so the last segment may still
// wait there while new samples are accepted. last_of_run marks the final result
// of a pulse. Writing a new channel count clears all meter state and the pixel
// store at once (valid bits), so there is no clearing pass after reset.
module peak_meter_bar_render_top
  import pmbr_pkg::*;
#(
  parameter int CHANNELS = 2,
  parameter int SEGMENTS = 16
) (
  input  wire logic   clk,
  input  wire logic   rst,
  pmbr_req_if.sink    req,
  pmbr_res_if.source  res,
  pmbr_cfg_if.sink    cfg
);

  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SEG_W  = $clog2(SEGMENTS);
  localparam int DEPTH  = CHANNELS * SEGMENTS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int ROWS   = 2 * SEGMENTS;
  localparam int PROD_W = LEVEL_W + $clog2(ROWS);
  localparam int RW     = PROD_W - 15;           // row width
  localparam logic [SEG_W-1:0] SEG_LAST = SEG_W'(SEGMENTS - 1);
  localparam logic [2:0]       CH_MAX   = 3'(CHANNELS);

  // row = round(level*(rows-1)/32768), raised to even; segment = row/2
  function automatic logic [RW-1:0] level_segment(input logic [LEVEL_W-1:0] lvl);
    logic [PROD_W-1:0] prod;
    logic [RW:0]       row1;
    prod = PROD_W'(lvl) * PROD_W'(ROWS - 1) + PROD_W'(FULL_SCALE >> 1);
    row1 = (RW + 1)'(prod[PROD_W-1:15]) + (RW + 1)'(1);
    return row1[RW:1];
  endfunction

  // configuration
  logic [2:0]         active;
  logic [15:0]        decay_gain;
  logic [FADE_W-1:0]  fade_gain;
  logic [TIMER_W-1:0] hold;
  logic               locked;
  logic [2:0]         n_eff;
  logic               cfg_wr;
  logic               flush;

  // per-channel meter state
  logic [LEVEL_W-1:0] rmax  [CHANNELS];
  logic [LEVEL_W-1:0] held  [CHANNELS];
  logic [TIMER_W-1:0] timer [CHANNELS];

  // sequencer
  pmbr_state_t state, state_next;
  logic [CH_W-1:0]  cur_ch;
  logic [SEG_W-1:0] seg;
  logic [31:0]      decay_prod;
  logic [RW-1:0]    cur_seg;
  logic [RW-1:0]    peak_seg;
  logic             req_acc;
  logic             slot_free;
  logic             mem_rd;
  logic             mem_wr;
  logic [ADDR_W-1:0] addr;
  pixel_t           old_px;
  pixel_t           new_px;
  seg_ctl_t         ctl;
  logic [LEVEL_W-1:0] decayed;
  logic [LEVEL_W-1:0] sample_max;

  // output register
  logic       res_valid;
  logic [1:0] res_channel;
  logic [3:0] res_segment;
  pixel_t     res_px;
  logic       res_last;

  assign cfg.ready = 1'b1;
  assign cfg_wr    = cfg.valid && cfg.ready;
  assign flush     = cfg_wr && (cfg.index == CFG_ACTIVE) && (cfg.data[2:0] != active);
  assign n_eff     = (active > CH_MAX) ? CH_MAX : active;
  assign req_acc   = req.valid && req.ready;
  assign slot_free = !res_valid || res.ready;
  assign addr      = ADDR_W'(int'(cur_ch) * SEGMENTS + int'(seg));
  assign decayed   = decay_prod[31:16];
  assign sample_max = (req.level > rmax[req.channel[CH_W-1:0]]) ?
                      req.level : rmax[req.channel[CH_W-1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= ACTIVE_RST;
      decay_gain <= DECAY_RST;
      fade_gain  <= FADE_RST;
      hold       <= HOLD_RST;
      locked     <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg.index)
        CFG_ACTIVE: active     <= cfg.data[2:0];
        CFG_DECAY:  decay_gain <= cfg.data;
        CFG_FADE:   fade_gain  <= cfg.data[FADE_W-1:0];
        CFG_HOLD:   hold       <= cfg.data[TIMER_W-1:0];
        CFG_LOCKED: locked     <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_acc && req.req_type == REQ_PULSE && n_eff != 3'd0) begin
          state_next = ST_DECAY;
        end
      end
      ST_DECAY:  state_next = ST_HOLD;
      ST_HOLD:   state_next = ST_LOCATE;
      ST_LOCATE: state_next = ST_READ;
      ST_READ:   state_next = ST_WRITE;
      ST_WRITE: begin
        if (slot_free) begin
          state_next = (seg == SEG_LAST) ? ST_CLOSE : ST_READ;
        end
      end
      ST_CLOSE:  state_next = (cur_ch == '0) ? ST_IDLE : ST_DECAY;
      default:   state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    req.ready = 1'b0;
    mem_rd    = 1'b0;
    mem_wr    = 1'b0;
    case (state)
      ST_IDLE:  req.ready = 1'b1;
      ST_READ:  mem_rd    = 1'b1;
      ST_WRITE: mem_wr    = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || flush) begin
      for (int c = 0; c < CHANNELS; c++) begin
        rmax[c]  <= '0;
        held[c]  <= '0;
        timer[c] <= '0;
      end
    end else begin
      case (state)
        ST_IDLE: begin
          if (req_acc && req.req_type == REQ_SAMPLE && {1'b0, req.channel} < n_eff) begin
            rmax[req.channel[CH_W-1:0]] <= sample_max;
            if (sample_max > FULL_SCALE) begin
              timer[req.channel[CH_W-1:0]] <= hold;
            end
          end
          if (req_acc && req.req_type == REQ_RESET_PEAKS) begin
            for (int c = 0; c < CHANNELS; c++) begin
              if (3'(c) < n_eff) begin
                timer[c] <= '0;
                held[c]  <= rmax[c];
              end
            end
          end
        end
        ST_HOLD: begin
          if (!locked) begin
            held[cur_ch] <= (rmax[cur_ch] > decayed) ? rmax[cur_ch] : decayed;
          end
        end
        ST_CLOSE: begin
          rmax[cur_ch] <= '0;
          if (timer[cur_ch] != '0) begin
            timer[cur_ch] <= timer[cur_ch] - TIMER_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_ch <= '0;
      seg    <= '0;
    end else begin
      if (state == ST_IDLE && state_next == ST_DECAY) begin
        cur_ch <= CH_W'(n_eff - 3'd1);
      end
      if (state == ST_CLOSE && cur_ch != '0) begin
        cur_ch <= cur_ch - CH_W'(1);
      end
      if (state == ST_LOCATE) begin
        seg <= '0;
      end
      if (mem_wr && seg != SEG_LAST) begin
        seg <= seg + SEG_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DECAY) begin
      decay_prod <= 32'(held[cur_ch]) * 32'(decay_gain);
    end
    if (state == ST_LOCATE) begin
      cur_seg  <= level_segment(rmax[cur_ch]);
      peak_seg <= level_segment(held[cur_ch]);
    end
  end

  assign ctl.below    = RW'(seg) < cur_seg;
  assign ctl.at_cur   = RW'(seg) == cur_seg;
  assign ctl.at_peak  = RW'(seg) == peak_seg;
  assign ctl.top_over = (timer[cur_ch] != '0) && (seg == SEG_LAST);

  pmbr_pixel_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .flush   (flush),
    .rd_en   (mem_rd),
    .rd_addr (addr),
    .rd_data (old_px),
    .wr_en   (mem_wr),
    .wr_addr (addr),
    .wr_data (new_px)
  );

  pmbr_shade u_shade (
    .old_px    (old_px),
    .fade_gain (fade_gain),
    .ctl       (ctl),
    .new_px    (new_px)
  );

  // result register: loaded when the slot is free or being emptied
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (mem_wr) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_wr) begin
      res_channel <= 2'(cur_ch);
      res_segment <= 4'(seg);
      res_px      <= new_px;
      res_last    <= (cur_ch == '0) && (seg == SEG_LAST);
    end
  end

  assign res.valid       = res_valid;
  assign res.out_channel = res_channel;
  assign res.segment     = res_segment;
  assign res.red         = res_px.r;
  assign res.green       = res_px.g;
  assign res.blue        = res_px.b;
  assign res.last_of_run = res_last;

  // final result of a pulse is always the top segment of channel 0
  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.last_of_run) |->
      (res.out_channel == 2'd0 && res.segment == 4'(SEGMENTS - 1)))
    else $error("last_of_run on wrong segment");

  // held peak never ends up below the running maximum after the decay step
  a_hold_floor: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HOLD && !locked && !flush) |=> (held[cur_ch] >= rmax[cur_ch]))
    else $error("held peak below running maximum");

  // closing a channel clears its running maximum
  a_close_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLOSE) |=> (rmax[$past(cur_ch)] == '0))
    else $error("running maximum not cleared");

  // a RAM write only happens when the previous result has gone or is leaving
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.ready) |=> !$past(mem_wr))
    else $error("pending result overwritten");

endmodule

`default_nettype wire
